// ===== rtl/brfp_pkg.sv =====
// Package for the byte ring FIFO with peek: command and status codes,
// default sizes and the packed request and response word types.
// No dependencies.
package brfp_pkg;

   localparam int unsigned DEPTH_DEFAULT   = 256;
   localparam int unsigned MAX_OUT_DEFAULT = 64;

   // Compare width: holds any amount and any count up to the largest ring
   localparam int unsigned CMP_W = 9;

   localparam logic [2:0] CMD_WRITE      = 3'd0;
   localparam logic [2:0] CMD_READ       = 3'd1;
   localparam logic [2:0] CMD_PEEK_ONE   = 3'd2;
   localparam logic [2:0] CMD_PEEK_RANGE = 3'd3;
   localparam logic [2:0] CMD_REMOVE     = 3'd4;
   localparam logic [2:0] CMD_QUERY      = 3'd5;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_in;
      logic [7:0] amount;
      logic       burst_start;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       data_valid;
      logic [7:0] result_count;
      logic [7:0] position;
      logic [1:0] status;
      logic       overflow;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/brfp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module brfp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/byte_ring_fifo_with_peek_unit.sv =====
// Byte ring FIFO with peek: top level with command sequencer and index logic.
// Depends on brfp_pkg (types, codes) and brfp_ram (ring storage).
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  brfp_pkg::req_type
//   rsp       out         rsp_valid / rsp_stall  brfp_pkg::rsp_type
//
// Sequence: a word is taken in S_IDLE and worked in S_EXEC, where single-result
// commands answer; read and peek commands then pass S_FETCH and S_EMIT for
// every byte, since every byte goes through one RAM read (address, then
// registered data). S_EXEC and S_EMIT both wait while rsp stalls.
// Reset: synchronous, active high; clears indices, burst state, overflow and
// the sequencer. The ring contents are not cleared.
// Stalls: rsp_stall holds the output register; the sequencer waits on it.
module byte_ring_fifo_with_peek_unit #(
   parameter int unsigned DEPTH   = brfp_pkg::DEPTH_DEFAULT,
   parameter int unsigned MAX_OUT = brfp_pkg::MAX_OUT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  brfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output brfp_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(MAX_OUT + 1);
   localparam int unsigned CW    = brfp_pkg::CMP_W;
   localparam logic [IDX_W:0]  DEPTH_X = (IDX_W + 1)'(DEPTH);
   localparam logic [CW-1:0]   MAXO_C  = CW'(MAX_OUT);
   localparam logic [CW-1:0]   DFREE_C = CW'(DEPTH - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] n);
      logic [IDX_W:0] sum;
      sum = {1'b0, idx} + {1'b0, n};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [1:0]              state_ff, state_in;
   brfp_pkg::req_type       req_ff, req_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        wi_ff, wi_in;
   logic [IDX_W-1:0]        ri_ff, ri_in;
   logic                    ovf_ff, ovf_in;
   logic [7:0]              bl_ff, bl_in;
   logic                    bacc_ff, bacc_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic                    adv_ff, adv_in;
   brfp_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    out_free;
   logic                    emit;
   logic                    ram_we;
   logic [7:0]              ram_rdata;
   logic [IDX_W-1:0]        cnt_now;
   logic [CW-1:0]           amt9;
   logic [CW-1:0]           cnt9;
   logic [CW-1:0]           rd_min;
   logic [CW-1:0]           rd_k9;
   logic [CW-1:0]           pr_k9;
   logic [IDX_W-1:0]        rm_k;
   logic [IDX_W:0]          run_len;
   logic                    emit_last;

   // Stored count from the indices, latched when a word is taken
   assign cnt_now = (wi_ff >= ri_ff) ? (wi_ff - ri_ff)
                  : IDX_W'(DEPTH_X + {1'b0, wi_ff} - {1'b0, ri_ff});

   assign amt9    = CW'(req_ff.amount);
   assign cnt9    = CW'(cnt_ff);
   assign rd_min  = (cnt9 < amt9) ? cnt9 : amt9;
   assign rd_k9   = (rd_min > MAXO_C) ? MAXO_C : rd_min;
   assign pr_k9   = ((amt9 + 1'b1) > MAXO_C) ? MAXO_C : (amt9 + 1'b1);
   assign rm_k    = (amt9 < cnt9) ? IDX_W'(req_ff.amount) : cnt_ff;
   assign run_len = (wi_ff >= ri_ff) ? {1'b0, wi_ff - ri_ff} : (DEPTH_X - {1'b0, ri_ff});
   assign emit_last = (CNT_W'(i_ff + 1'b1) == k_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic [7:0] bl_v;
      logic       acc_v;
      logic       ovf_v;

      state_in = state_ff;
      req_in   = req_ff;
      cnt_in   = cnt_ff;
      wi_in    = wi_ff;
      ri_in    = ri_ff;
      ovf_in   = ovf_ff;
      bl_in    = bl_ff;
      bacc_in  = bacc_ff;
      addr_in  = addr_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      adv_in   = adv_ff;
      emit     = 1'b0;
      ram_we   = 1'b0;
      bl_v     = bl_ff;
      acc_v    = bacc_ff;
      ovf_v    = ovf_ff;
      rsp_in   = '0;
      rsp_in.overflow = ovf_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               cnt_in   = cnt_now;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_in.last = 1'b1;
               state_in    = S_IDLE;
               unique case (req_ff.cmd)
                  brfp_pkg::CMD_WRITE: begin
                     if (req_ff.burst_start) begin
                        bl_v = req_ff.amount;
                        if (amt9 <= (DFREE_C - cnt9)) begin
                           acc_v = 1'b1;
                        end else begin
                           acc_v = 1'b0;
                           ovf_v = 1'b1;
                        end
                     end
                     priority if (req_ff.burst_start && req_ff.amount == 8'd0) begin
                        rsp_in.status = brfp_pkg::STAT_OK;
                     end else if (bl_v != 8'd0 && acc_v) begin
                        ram_we = 1'b1;
                        wi_in  = wrap_add(wi_ff, IDX_W'(1));
                        bl_v   = bl_v - 8'd1;
                        rsp_in.result_count = 8'd1;
                     end else begin
                        if (bl_v != 8'd0) begin
                           bl_v = bl_v - 8'd1;
                        end
                        rsp_in.status = brfp_pkg::STAT_REJECT;
                     end
                     bl_in   = bl_v;
                     bacc_in = acc_v;
                     ovf_in  = ovf_v;
                     rsp_in.overflow = ovf_v;
                  end
                  brfp_pkg::CMD_READ: begin
                     if (rd_k9 == '0) begin
                        rsp_in.status = (cnt_ff == '0) ? brfp_pkg::STAT_EMPTY
                                                       : brfp_pkg::STAT_OK;
                     end else begin
                        emit     = 1'b0;
                        k_in     = CNT_W'(rd_k9);
                        i_in     = '0;
                        addr_in  = ri_ff;
                        adv_in   = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  brfp_pkg::CMD_PEEK_ONE: begin
                     if (amt9 < cnt9) begin
                        emit     = 1'b0;
                        k_in     = CNT_W'(1);
                        i_in     = '0;
                        addr_in  = wrap_add(ri_ff, IDX_W'(req_ff.amount));
                        adv_in   = 1'b0;
                        state_in = S_FETCH;
                     end else begin
                        rsp_in.status = brfp_pkg::STAT_EMPTY;
                     end
                  end
                  brfp_pkg::CMD_PEEK_RANGE: begin
                     if (amt9 < cnt9) begin
                        emit     = 1'b0;
                        k_in     = CNT_W'(pr_k9);
                        i_in     = '0;
                        addr_in  = ri_ff;
                        adv_in   = 1'b0;
                        state_in = S_FETCH;
                     end else begin
                        rsp_in.status = brfp_pkg::STAT_EMPTY;
                     end
                  end
                  brfp_pkg::CMD_REMOVE: begin
                     if (req_ff.amount != 8'd0) begin
                        ri_in  = wrap_add(ri_ff, rm_k);
                        ovf_in = 1'b0;
                        rsp_in.overflow = 1'b0;
                        if (cnt_ff == '0) begin
                           rsp_in.status = brfp_pkg::STAT_EMPTY;
                        end
                     end
                     rsp_in.result_count = 8'(rm_k);
                  end
                  brfp_pkg::CMD_QUERY: begin
                     rsp_in.result_count = 8'(run_len);
                     rsp_in.position     = 8'(ri_ff);
                  end
                  default: begin
                     rsp_in.status = brfp_pkg::STAT_EMPTY;
                  end
               endcase
            end
         end
         S_FETCH: begin
            // RAM data lands at the end of this cycle
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit                = 1'b1;
               rsp_in.data_out     = ram_rdata;
               rsp_in.data_valid   = 1'b1;
               rsp_in.result_count = 8'(k_ff);
               rsp_in.last         = emit_last;
               if (adv_ff) begin
                  ri_in = wrap_add(ri_ff, IDX_W'(1));
               end
               addr_in  = wrap_add(addr_ff, IDX_W'(1));
               i_in     = CNT_W'(i_ff + 1'b1);
               state_in = emit_last ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wi_ff        <= '0;
         ri_ff        <= '0;
         ovf_ff       <= 1'b0;
         bl_ff        <= '0;
         bacc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wi_ff        <= wi_in;
         ri_ff        <= ri_in;
         ovf_ff       <= ovf_in;
         bl_ff        <= bl_in;
         bacc_ff      <= bacc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      cnt_ff  <= cnt_in;
      addr_ff <= addr_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      adv_ff  <= adv_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   brfp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wi_ff),
      .wr_data (req_ff.data_in),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Indices always stay inside the ring
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (wi_ff < DEPTH_X[IDX_W-1:0] || DEPTH_X[IDX_W]) &&
      ({1'b0, wi_ff} < DEPTH_X) && ({1'b0, ri_ff} < DEPTH_X))
      else $error("ring index out of range");

   // A stored byte never fills the reserved empty slot
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, cnt_now} < (DEPTH_X - 1'b1)))
      else $error("write into a full ring");

   // Byte counter stays below the item's byte total while emitting
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (i_ff < k_ff))
      else $error("emit counter past item length");

   // Every byte emit comes after a RAM fetch, or holds from a stalled emit
   a_fetch_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> ($past(state_ff) == S_FETCH || $past(state_ff) == S_EMIT))
      else $error("emit without fetch");

endmodule

// ===== bench/brfp_checker.sv =====
// Checker for the byte ring FIFO with peek: watches the req and rsp channels,
// keeps its own copy of the ring and indices, and compares every rsp word.
// Depends on brfp_pkg for the word types and the command and status codes.
module brfp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  brfp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  brfp_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_count,
   output int                checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING    = int'(brfp_pkg::DEPTH_DEFAULT);
   localparam int OUT_CAP = int'(brfp_pkg::MAX_OUT_DEFAULT);

   logic [7:0]        ring_copy [RING];
   int                wr_at;
   int                rd_at;
   int                burst_rem;
   logic              burst_ok;
   logic              ovf;
   brfp_pkg::rsp_type due_rsp [$];
   int                mismatches = 0;
   int                checked = 0;

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
   end

   task automatic owe(input logic [7:0] d, input logic v, input int cnt, input int pos,
                      input logic [1:0] st, input logic fin);
      brfp_pkg::rsp_type r;
      r.data_out     = d;
      r.data_valid   = v;
      r.result_count = cnt[7:0];
      r.position     = pos[7:0];
      r.status       = st;
      r.overflow     = ovf;
      r.last         = fin;
      due_rsp.push_back(r);
   endtask

   task automatic apply_command(input brfp_pkg::req_type w);
      int held;
      int k;
      int i;
      held = (wr_at + RING - rd_at) % RING;
      case (w.cmd)
         brfp_pkg::CMD_WRITE: begin
            if (w.burst_start) begin
               // a new start drops whatever was left of the previous burst
               burst_rem = int'(w.amount);
               if (int'(w.amount) <= RING - 1 - held) begin
                  burst_ok = 1'b1;
               end else begin
                  burst_ok = 1'b0;
                  ovf      = 1'b1;
               end
            end
            if (w.burst_start && w.amount == 8'd0) begin
               owe(8'd0, 1'b0, 0, 0, brfp_pkg::STAT_OK, 1'b1);
            end else if (burst_rem > 0 && burst_ok) begin
               ring_copy[wr_at] = w.data_in;
               wr_at = (wr_at + 1) % RING;
               burst_rem--;
               owe(8'd0, 1'b0, 1, 0, brfp_pkg::STAT_OK, 1'b1);
            end else begin
               if (burst_rem > 0) burst_rem--;
               owe(8'd0, 1'b0, 0, 0, brfp_pkg::STAT_REJECT, 1'b1);
            end
         end
         brfp_pkg::CMD_READ: begin
            k = (held < int'(w.amount)) ? held : int'(w.amount);
            if (k > OUT_CAP) k = OUT_CAP;
            if (k == 0) begin
               owe(8'd0, 1'b0, 0, 0,
                   (held == 0) ? brfp_pkg::STAT_EMPTY : brfp_pkg::STAT_OK, 1'b1);
            end else begin
               for (i = 0; i < k; i++) begin
                  owe(ring_copy[rd_at], 1'b1, k, 0, brfp_pkg::STAT_OK, i == k - 1);
                  rd_at = (rd_at + 1) % RING;
               end
            end
         end
         brfp_pkg::CMD_PEEK_ONE: begin
            if (int'(w.amount) < held)
               owe(ring_copy[(rd_at + int'(w.amount)) % RING], 1'b1, 1, 0,
                   brfp_pkg::STAT_OK, 1'b1);
            else
               owe(8'd0, 1'b0, 0, 0, brfp_pkg::STAT_EMPTY, 1'b1);
         end
         brfp_pkg::CMD_PEEK_RANGE: begin
            if (int'(w.amount) < held) begin
               k = int'(w.amount) + 1;
               if (k > OUT_CAP) k = OUT_CAP;
               for (i = 0; i < k; i++)
                  owe(ring_copy[(rd_at + i) % RING], 1'b1, k, 0, brfp_pkg::STAT_OK,
                      i == k - 1);
            end else begin
               owe(8'd0, 1'b0, 0, 0, brfp_pkg::STAT_EMPTY, 1'b1);
            end
         end
         brfp_pkg::CMD_REMOVE: begin
            // clamp to what is stored; any non-zero request clears overflow
            k = (int'(w.amount) < held) ? int'(w.amount) : held;
            if (w.amount != 8'd0) begin
               rd_at = (rd_at + k) % RING;
               ovf   = 1'b0;
            end
            owe(8'd0, 1'b0, k, 0,
                (w.amount != 8'd0 && held == 0) ? brfp_pkg::STAT_EMPTY
                                                : brfp_pkg::STAT_OK, 1'b1);
         end
         brfp_pkg::CMD_QUERY: begin
            k = (wr_at >= rd_at) ? wr_at - rd_at : RING - rd_at;
            owe(8'd0, 1'b0, k, rd_at, brfp_pkg::STAT_OK, 1'b1);
         end
         default: owe(8'd0, 1'b0, 0, 0, brfp_pkg::STAT_EMPTY, 1'b1);
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: rsp %s expected %0h got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      brfp_pkg::rsp_type want;
      if (reset) begin
         wr_at     = 0;
         rd_at     = 0;
         burst_rem = 0;
         burst_ok  = 1'b0;
         ovf       = 1'b0;
         due_rsp.delete();
      end else begin
         if (req_valid && !req_stall) apply_command(req_data);
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (due_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: rsp word %h with nothing expected", $time, rsp_data);
            end else begin
               want = due_rsp.pop_front();
               check_field("data_out", want.data_out, rsp_data.data_out);
               check_field("data_valid", 8'(want.data_valid), 8'(rsp_data.data_valid));
               check_field("result_count", want.result_count, rsp_data.result_count);
               check_field("position", want.position, rsp_data.position);
               check_field("status", 8'(want.status), 8'(rsp_data.status));
               check_field("overflow", 8'(want.overflow), 8'(rsp_data.overflow));
               check_field("last", 8'(want.last), 8'(rsp_data.last));
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= due_rsp.size();
      checked_count <= checked;
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, req stimulus and rsp stall pattern for
// byte_ring_fifo_with_peek_unit, with brfp_checker beside it for the verdict.
// Depends on brfp_pkg, the unit and bench/brfp_checker.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORK_WORDS  = 450;
   localparam int DRAIN_WAIT  = 150;
   localparam int CYCLE_LIMIT = 3000000;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   brfp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   brfp_pkg::rsp_type rsp_data;

   int   error_count;
   int   pending_count;
   int   checked_count;
   int   cycle_count = 0;
   int   sent_words = 0;
   int   ignored_words = 0;
   int   bursts = 0;
   int   hold_left = 0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   byte_ring_fifo_with_peek_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   brfp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d rsp words outstanding",
                  cycle_count, pending_count);
         $display("testbench: errors");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   function automatic logic [7:0] pick_amount();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 8'($urandom_range(0, 8));
      if (roll < 85) return 8'($urandom_range(9, 80));
      return 8'($urandom_range(81, 255));
   endfunction

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
      if ($urandom_range(0, 299) == 0) rsp_calm <= !rsp_calm;
   end

   task automatic send_word(input logic [2:0] op, input logic [7:0] byte_val,
                            input logic [7:0] amt, input logic first);
      brfp_pkg::req_type w;
      int                gap;
      w.cmd         = op;
      w.data_in     = byte_val;
      w.amount      = amt;
      w.burst_start = first;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sent_words++;
      if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
   endtask

   // keep < len abandons the burst early
   task automatic send_burst(input logic [7:0] len, input int keep);
      int i;
      send_word(brfp_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), len, 1'b1);
      for (i = 1; i < keep; i++)
         send_word(brfp_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b0);
      bursts++;
   endtask

   initial begin : stimulus
      int roll;
      int len;
      int keep;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty FIFO corners
      send_word(brfp_pkg::CMD_QUERY, 8'h00, 8'h00, 1'b0);
      send_word(brfp_pkg::CMD_READ, 8'h00, 8'd5, 1'b0);
      send_word(brfp_pkg::CMD_PEEK_ONE, 8'h00, 8'd0, 1'b0);
      send_word(brfp_pkg::CMD_PEEK_RANGE, 8'h00, 8'd0, 1'b0);
      send_word(brfp_pkg::CMD_REMOVE, 8'h00, 8'd3, 1'b0);
      send_word(brfp_pkg::CMD_REMOVE, 8'h00, 8'd0, 1'b0);
      // stray byte, then an empty burst
      send_word(brfp_pkg::CMD_WRITE, 8'hFF, 8'hFF, 1'b0);
      send_word(brfp_pkg::CMD_WRITE, 8'h5A, 8'd0, 1'b1);
      send_word(brfp_pkg::CMD_WRITE, 8'h00, 8'd3, 1'b1);
      send_word(brfp_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b0);
      send_word(brfp_pkg::CMD_WRITE, 8'hA5, 8'hFF, 1'b0);
      bursts += 2;
      send_word(brfp_pkg::CMD_READ, 8'h00, 8'd0, 1'b0);
      send_word(brfp_pkg::CMD_PEEK_ONE, 8'h00, 8'd2, 1'b0);
      send_word(brfp_pkg::CMD_PEEK_ONE, 8'h00, 8'd3, 1'b0);
      send_word(brfp_pkg::CMD_PEEK_RANGE, 8'h00, 8'd1, 1'b0);
      send_word(brfp_pkg::CMD_QUERY, 8'h00, 8'h00, 1'b0);
      // burst too large for the room left: rejected, overflow sticks
      send_word(brfp_pkg::CMD_WRITE, 8'h11, 8'd255, 1'b1);
      send_word(brfp_pkg::CMD_WRITE, 8'h22, 8'd0, 1'b0);
      bursts++;
      send_word(3'd6, 8'hFF, 8'hFF, 1'b1);
      send_word(3'd7, 8'h00, 8'h00, 1'b0);
      send_word(brfp_pkg::CMD_REMOVE, 8'h00, 8'd1, 1'b0);
      send_word(brfp_pkg::CMD_READ, 8'h00, 8'd255, 1'b0);

      // fill the ring completely, then force saturated output
      send_word(brfp_pkg::CMD_REMOVE, 8'h00, 8'd255, 1'b0);
      send_burst(8'd255, 255);
      send_burst(8'd1, 1);
      send_word(brfp_pkg::CMD_PEEK_RANGE, 8'h00, 8'd200, 1'b0);
      send_word(brfp_pkg::CMD_READ, 8'h00, 8'd255, 1'b0);
      send_word(brfp_pkg::CMD_QUERY, 8'h00, 8'h00, 1'b0);

      while (sent_words < WORK_WORDS) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) len = $urandom_range(1, 12);
            else if (roll < 80) len = 0;
            else if (roll < 92) len = $urandom_range(13, 40);
            else len = $urandom_range(41, 120);
            keep = (len == 0) ? 1 : len;
            if (len > 1 && $urandom_range(0, 9) == 0) keep = $urandom_range(1, len - 1);
            send_burst(len[7:0], keep);
         end else if (roll < 40) begin
            send_word(brfp_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'b0);
            ignored_words++;
         end else if (roll < 55) begin
            send_word(brfp_pkg::CMD_READ, 8'($urandom_range(0, 255)), pick_amount(), 1'b0);
         end else if (roll < 65) begin
            send_word(brfp_pkg::CMD_PEEK_ONE, 8'($urandom_range(0, 255)), pick_amount(),
                      1'b0);
         end else if (roll < 75) begin
            send_word(brfp_pkg::CMD_PEEK_RANGE, 8'($urandom_range(0, 255)), pick_amount(),
                      1'b0);
         end else if (roll < 84) begin
            send_word(brfp_pkg::CMD_REMOVE, 8'($urandom_range(0, 255)), pick_amount(),
                      1'b0);
         end else if (roll < 96) begin
            send_word(brfp_pkg::CMD_QUERY, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            send_word(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            ignored_words++;
         end
      end
      req_valid <= 1'b0;

      // let the checker count the last accepted word before waiting on it
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d req words (%0d bursts, %0d ignored) in %0d cycles",
               sent_words, bursts, ignored_words, cycle_count);
      $display("compared %0d rsp words, %0d mismatches", checked_count, error_count);
      if (error_count == 0 && pending_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
